// File: hw/rtl/circular_double_ended_queue_macros.svh
// Assertion macros for the deque checker.
// Both expect clk and rst to be visible where they are used.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH

// Property that must hold at every edge outside reset.
`define CDQ_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("deque check failed");

// Consequence that must hold in the cycle after the antecedent.
`define CDQ_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

// File: hw/rtl/cdq_pkg.sv
package cdq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int CAP_W         = 5;
  localparam int OP_W          = 3;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_BACK  = 3'd3,
    OP_READ      = 3'd4
  } op_t;

endpackage

// File: hw/rtl/cdq_req_if.sv
interface cdq_req_if #(
  parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [cdq_pkg::OP_W-1:0]   op;
  logic signed [WORD_BITS-1:0] value;

  modport source (output valid, op, value, input ready);
  modport sink   (input valid, op, value, output ready);
endinterface

// File: hw/rtl/cdq_rsp_if.sv
interface cdq_rsp_if #(
  parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic signed [WORD_BITS-1:0] front_value;
  logic signed [WORD_BITS-1:0] rear_value;
  logic                        is_empty;
  logic                        is_full;
  logic [cdq_pkg::CAP_W-1:0]   count;

  modport source (output valid, accepted, front_value, rear_value, is_empty, is_full, count,
                  input ready);
  modport sink   (input valid, accepted, front_value, rear_value, is_empty, is_full, count,
                  output ready);
endinterface

// File: hw/rtl/cdq_ram.sv
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hw/rtl/circular_double_ended_queue.sv
// Circular double-ended queue of signed words.
// Channels: req carries op and value, rsp returns accepted, front_value,
// rear_value, is_empty, is_full and count; both are valid/ready, an item
// moves when valid and ready are high at a clock edge.
// cfg_we/cfg_data write the capacity (0 acts as 1, above DEPTH as DEPTH);
// write it only while no item is in flight.
// Result: the result of an item is on rsp in the cycle after it is accepted.
// Throughput: one item per cycle unless stalled; pointer update and slot
// write finish in the accept cycle, the RAM read registers with the result.
// Stall: rsp holds while ready is low; req.ready stays high while the
// result register is empty or being drained, so one result may wait
// while the next item is taken in the same cycle it leaves.
// Reset: empty deque, both ends at slot 0, capacity 16, no result pending.
// Slot contents are not cleared; an empty deque reports -1 at both ends.
module circular_double_ended_queue #(
  parameter int DEPTH     = cdq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0]  cfg_data,
  cdq_req_if.sink                    req,
  cdq_rsp_if.source                  rsp
);

  import cdq_pkg::*;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W   = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
  localparam int CAP_MAX = (DEPTH < (1 << CAP_W) - 1) ? DEPTH : (1 << CAP_W) - 1;

  function automatic logic [PTR_W-1:0] step_up(logic [PTR_W-1:0] p, logic [CAP_W-1:0] c);
    logic [CMP_W-1:0] n;
    n = CMP_W'(p) + CMP_W'(1);
    return (n >= CMP_W'(c)) ? '0 : PTR_W'(n);
  endfunction

  function automatic logic [PTR_W-1:0] step_down(logic [PTR_W-1:0] p, logic [CAP_W-1:0] c);
    logic [CMP_W-1:0] m;
    m = CMP_W'(c) - CMP_W'(1);
    return (p == '0) ? PTR_W'(m) : p - PTR_W'(1);
  endfunction

  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] eff_cap;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CAP_W-1:0] fill, fill_next;
  logic             full, empty, ok, accept;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;

  logic                 out_valid;
  logic                 ok_q, empty_q, full_q, front_hit_q, rear_hit_q;
  logic [CAP_W-1:0]     count_q;
  logic [WORD_BITS-1:0] wdata_q;
  logic [WORD_BITS-1:0] rd_front, rd_rear;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CAP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(CAP_MAX)) begin
      eff_cap = CAP_W'(CAP_MAX);
    end else begin
      eff_cap = capacity;
    end
  end

  assign full      = (fill >= eff_cap);
  assign empty     = (fill == '0);
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    ok        = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = head;
    case (op_t'(req.op))
      OP_INS_FRONT, OP_INS_BACK: begin
        if (full) begin
          ok = 1'b0;
        end else begin
          if (empty) begin
            head_next = '0;
            tail_next = '0;
          end else if (op_t'(req.op) == OP_INS_FRONT) begin
            head_next = step_down(head, eff_cap);
          end else begin
            tail_next = step_up(tail, eff_cap);
          end
          wr_en     = 1'b1;
          wr_addr   = (op_t'(req.op) == OP_INS_FRONT) ? head_next : tail_next;
          fill_next = fill + CAP_W'(1);
        end
      end
      OP_DEL_FRONT: begin
        if (empty) begin
          ok = 1'b0;
        end else begin
          head_next = step_up(head, eff_cap);
          fill_next = fill - CAP_W'(1);
        end
      end
      OP_DEL_BACK: begin
        if (empty) begin
          ok = 1'b0;
        end else begin
          tail_next = step_down(tail, eff_cap);
          fill_next = fill - CAP_W'(1);
        end
      end
      default: begin
        ok = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        head      <= head_next;
        tail      <= tail_next;
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result fields; a slot written in the accept cycle bypasses the RAM read
  always_ff @(posedge clk) begin
    if (accept) begin
      ok_q        <= ok;
      empty_q     <= (fill_next == '0);
      full_q      <= (fill_next >= eff_cap);
      count_q     <= fill_next;
      front_hit_q <= wr_en && (wr_addr == head_next);
      rear_hit_q  <= wr_en && (wr_addr == tail_next);
      wdata_q     <= req.value;
    end
  end

  cdq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .we      (accept && wr_en),
    .waddr   (wr_addr),
    .wdata   (req.value),
    .re      (accept),
    .raddr_a (head_next),
    .raddr_b (tail_next),
    .rdata_a (rd_front),
    .rdata_b (rd_rear)
  );

  assign rsp.valid       = out_valid;
  assign rsp.accepted    = ok_q;
  assign rsp.is_empty    = empty_q;
  assign rsp.is_full     = full_q;
  assign rsp.count       = count_q;
  assign rsp.front_value = empty_q ? '1 : (front_hit_q ? wdata_q : rd_front);
  assign rsp.rear_value  = empty_q ? '1 : (rear_hit_q ? wdata_q : rd_rear);

endmodule

// File: hw/rtl/cdq_checker.sv
`include "circular_double_ended_queue_macros.svh"

module cdq_checker #(
  parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       is_empty,
  input logic                       is_full,
  input logic [cdq_pkg::CAP_W-1:0]  count,
  input logic [WORD_BITS-1:0]       front_value,
  input logic [WORD_BITS-1:0]       rear_value
);

  import cdq_pkg::*;

  `CDQ_CHECK(a_empty_reads_ones, !rsp_valid || !is_empty || (&front_value && &rear_value))
  `CDQ_CHECK(a_empty_matches_count, !rsp_valid || (is_empty == (count == '0)))
  `CDQ_CHECK(a_not_full_and_empty, !rsp_valid || !(is_full && is_empty))
  `CDQ_CHECK_NEXT(a_stall_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(count))

endmodule

bind circular_double_ended_queue cdq_checker #(
  .WORD_BITS (WORD_BITS)
) u_cdq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .is_empty    (rsp.is_empty),
  .is_full     (rsp.is_full),
  .count       (rsp.count),
  .front_value (rsp.front_value),
  .rear_value  (rsp.rear_value)
);

// File: verif/circular_double_ended_queue_tb.sv
module circular_double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int WB             = WORD_BITS_DEF;
  localparam int PTR_W          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OP_CODE_MAX    = (1 << OP_W) - 1;
  localparam int GAP_MAX        = 17;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_ITEMS     = 40;
  localparam int PHASE_ITEMS    = 70;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic             accepted;
    logic [WB-1:0]    front_value;
    logic [WB-1:0]    rear_value;
    logic             is_empty;
    logic             is_full;
    logic [CAP_W-1:0] count;
  } deque_view_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;

  cdq_req_if #(.WORD_BITS(WB)) req_ch ();
  cdq_rsp_if #(.WORD_BITS(WB)) rsp_ch ();

  circular_double_ended_queue #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WB)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // deque state as the block should hold it
  logic [WB-1:0]    ring [DEPTH];
  int               head_idx = 0;
  int               tail_idx = 0;
  int               fill_cnt = 0;
  logic [CAP_W-1:0] capacity_reg = CAP_RESET;
  deque_view_t      pending_views [$];

  int errors        = 0;
  int n_items       = 0;
  int n_results     = 0;
  int n_refused     = 0;
  int n_cap_writes  = 0;
  int req_gap_max   = GAP_MAX;
  int rsp_stall_max = GAP_MAX;
  int rsp_hold      = 0;
  int idle_cycles   = 0;

  function automatic int usable_slots();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > DEPTH) return DEPTH;
    return int'(capacity_reg);
  endfunction

  function automatic deque_view_t apply_request(input logic [OP_W-1:0] op,
                                                input logic [WB-1:0] value);
    deque_view_t v;
    int          cap;
    logic        was_full;
    logic        was_empty;
    cap        = usable_slots();
    was_full   = fill_cnt >= cap;
    was_empty  = fill_cnt == 0;
    v.accepted = 1'b1;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (was_full) begin
          v.accepted = 1'b0;
        end else begin
          if (was_empty) begin
            head_idx = 0;
            tail_idx = 0;
          end else if (op == OP_INS_FRONT) begin
            head_idx = (head_idx == 0) ? cap - 1 : head_idx - 1;
          end else begin
            tail_idx = (tail_idx + 1 >= cap) ? 0 : tail_idx + 1;
          end
          ring[PTR_W'((op == OP_INS_FRONT) ? head_idx : tail_idx)] = value;
          fill_cnt++;
        end
      end
      OP_DEL_FRONT: begin
        if (was_empty) begin
          v.accepted = 1'b0;
        end else begin
          head_idx = (head_idx + 1 >= cap) ? 0 : head_idx + 1;
          fill_cnt--;
        end
      end
      OP_DEL_BACK: begin
        if (was_empty) begin
          v.accepted = 1'b0;
        end else begin
          tail_idx = (tail_idx == 0) ? cap - 1 : tail_idx - 1;
          fill_cnt--;
        end
      end
      default: ;
    endcase
    v.is_empty    = fill_cnt == 0;
    v.front_value = v.is_empty ? '1 : ring[PTR_W'(head_idx)];
    v.rear_value  = v.is_empty ? '1 : ring[PTR_W'(tail_idx)];
    v.is_full     = fill_cnt >= cap;
    v.count       = CAP_W'(fill_cnt);
    if (!v.accepted) n_refused++;
    return v;
  endfunction

  function automatic void compare_field(input string name, input logic [WB-1:0] want,
                                        input logic [WB-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    deque_view_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_results++;
        if (pending_views.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual count %0d", $time,
                   rsp_ch.count);
        end else begin
          want = pending_views.pop_front();
          compare_field("accepted", WB'(want.accepted), WB'(rsp_ch.accepted));
          compare_field("front_value", want.front_value, rsp_ch.front_value);
          compare_field("rear_value", want.rear_value, rsp_ch.rear_value);
          compare_field("is_empty", WB'(want.is_empty), WB'(rsp_ch.is_empty));
          compare_field("is_full", WB'(want.is_full), WB'(rsp_ch.is_full));
          compare_field("count", WB'(want.count), WB'(rsp_ch.count));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        n_items++;
        pending_views.push_back(apply_request(req_ch.op, req_ch.value));
      end
      if (cfg_we) begin
        capacity_reg = cfg_data;
        n_cap_writes++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t no item moved for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side: random stall before each item, or one long hold-off on request
  initial begin : result_sink
    int stall;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (rsp_hold > 0) begin
        stall    = rsp_hold;
        rsp_hold = 0;
      end else begin
        stall = $urandom_range(0, rsp_stall_max);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  function automatic logic [WB-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int insert_bias);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return OP_W'($urandom_range(OP_READ + 1, OP_CODE_MAX));
    if (roll < 10) return OP_READ;
    if ($urandom_range(1, 100) <= insert_bias)
      return $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK;
    return $urandom_range(0, 1) ? OP_DEL_FRONT : OP_DEL_BACK;
  endfunction

  // leaves valid high at the accepting edge; a gap in the next call or a pause lowers it
  task automatic send_item(input logic [OP_W-1:0] op, input logic [WB-1:0] value);
    int gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.op    <= op;
    req_ch.value <= value;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_data <= cap;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // empty refusals, wrap at the front end, full refusals, unused op codes;
  // filling all slots here means every later capacity change reads written data
  task automatic test_directed_edges();
    logic [WB-1:0] extreme_words [4];
    extreme_words = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff};
    send_item(OP_DEL_FRONT, pick_value());
    send_item(OP_DEL_BACK, pick_value());
    send_item(OP_READ, pick_value());
    for (int i = 0; i < DEPTH; i++) begin
      send_item((i % 2) ? OP_INS_FRONT : OP_INS_BACK,
                (i < 4) ? extreme_words[i] : pick_value());
    end
    send_item(OP_INS_FRONT, pick_value());
    send_item(OP_INS_BACK, pick_value());
    for (int c = OP_READ + 1; c <= OP_CODE_MAX; c++) begin
      send_item(OP_W'(c), pick_value());
    end
  endtask

  task automatic test_output_backpressure();
    req_gap_max = 0;
    rsp_hold    = HOLD_CYCLES;
    repeat (HOLD_ITEMS) send_item(pick_op(50), pick_value());
    wait_for_results();
    req_gap_max = GAP_MAX;
  endtask

  task automatic test_capacity_sweep();
    logic [CAP_W-1:0] caps [11];
    int               insert_bias;
    caps = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd2, 5'd17, 5'd8, 5'd3, 5'd12, 5'd16, 5'd1};
    insert_bias = 50;
    foreach (caps[k]) begin
      wait_for_results();
      write_capacity(caps[k]);
      req_gap_max   = (k % 4 == 1 || k % 4 == 3) ? 0 : GAP_MAX;
      rsp_stall_max = (k % 4 == 2 || k % 4 == 3) ? 0 : GAP_MAX;
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if (j % 20 == 0) insert_bias = $urandom_range(15, 85);
        send_item(pick_op(insert_bias), pick_value());
      end
    end
    req_gap_max   = GAP_MAX;
    rsp_stall_max = GAP_MAX;
  endtask

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.op    <= OP_READ;
    req_ch.value <= '0;
    cfg_we       <= 1'b0;
    cfg_data     <= CAP_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_output_backpressure();
    test_capacity_sweep();

    wait_for_results();
    repeat (4) @(posedge clk);
    $display("Ran %0d items through %0d capacity writes (0, 1 to 16, above 16), %0d refused.",
             n_items, n_cap_writes, n_refused);
    $display("Checked %0d results with random stalls and one %0d-cycle output hold; %0d errors.",
             n_results, HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_req_if.sv
hw/rtl/cdq_rsp_if.sv
hw/rtl/cdq_ram.sv
hw/rtl/circular_double_ended_queue.sv
hw/rtl/cdq_checker.sv
verif/circular_double_ended_queue_tb.sv
